>>> rtl/gmdm_pkg.sv
// Shared types and constants for the gamepad mecanum drive mixer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package gmdm_pkg;

  // Gamepad button codes. Codes above BTN_R2 act like no button.
  localparam logic [3:0] BTN_NONE   = 4'd0;
  localparam logic [3:0] BTN_START  = 4'd1;
  localparam logic [3:0] BTN_SELECT = 4'd2;
  localparam logic [3:0] BTN_SQUARE = 4'd3;
  localparam logic [3:0] BTN_CROSS  = 4'd4;
  localparam logic [3:0] BTN_CIRCLE = 4'd5;
  localparam logic [3:0] BTN_L1     = 4'd6;
  localparam logic [3:0] BTN_L2     = 4'd7;
  localparam logic [3:0] BTN_R1     = 4'd8;
  localparam logic [3:0] BTN_R2     = 4'd9;

  // Drive modes. The code 3 only appears if INITIAL_MODE is set to it and
  // then behaves as a variable speed manual mode.
  localparam logic [1:0] MODE_FIXED = 2'd0;
  localparam logic [1:0] MODE_VAR   = 2'd1;
  localparam logic [1:0] MODE_EXT   = 2'd2;

  localparam logic [1:0] INITIAL_MODE      = MODE_VAR;
  localparam logic       INITIAL_MOTORS_ON = 1'b1;

  // Configuration register indexes and reset values.
  localparam logic [1:0] CFG_AXIS_THRESHOLD     = 2'd0;
  localparam logic [1:0] CFG_STICK_FIXED_SPEED  = 2'd1;
  localparam logic [1:0] CFG_BUTTON_FIXED_SPEED = 2'd2;
  localparam logic [1:0] CFG_DEBOUNCE_SECONDS   = 2'd3;

  localparam logic [6:0] RST_AXIS_THRESHOLD     = 7'd20;
  localparam logic [7:0] RST_STICK_FIXED_SPEED  = 8'd100;
  localparam logic [7:0] RST_BUTTON_FIXED_SPEED = 8'd100;
  localparam logic [7:0] RST_DEBOUNCE_SECONDS   = 8'd1;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BACK = 2'd2
  } dir_t;

  // One gamepad report, button in the lowest bits.
  typedef struct packed {
    logic [31:0]       now_seconds;
    logic signed [7:0] right_y;
    logic signed [7:0] right_x;
    logic signed [7:0] left_y;
    logic signed [7:0] left_x;
    logic [3:0]        button;
  } gmdm_report_t;

  typedef struct packed {
    logic         valid;
    gmdm_report_t report;
  } gmdm_stage_t;

  typedef struct packed {
    logic [6:0] axis_threshold;
    logic [7:0] stick_fixed_speed;
    logic [7:0] button_fixed_speed;
    logic [7:0] debounce_seconds;
  } gmdm_cfg_t;

  // Full drive state as reported, front right direction in the lowest bits.
  typedef struct packed {
    logic [1:0] drive_mode;
    logic       motors_enabled;
    logic [7:0] speed_rl;
    logic [7:0] speed_rr;
    logic [7:0] speed_fl;
    logic [7:0] speed_fr;
    dir_t       dir_rl;
    dir_t       dir_rr;
    dir_t       dir_fl;
    dir_t       dir_fr;
  } gmdm_result_t;

  localparam int RESULT_W = $bits(gmdm_result_t);
  localparam int REPORT_W = $bits(gmdm_report_t);

endpackage

>>> rtl/gmdm_cfg_regs.sv
// Configuration registers of the drive mixer, written through a plain port.
// Depends on gmdm_pkg.
`timescale 1ns / 1ps

module gmdm_cfg_regs import gmdm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_addr,
  input  logic [7:0] cfg_wdata,
  output gmdm_cfg_t  cfg
);

  gmdm_cfg_t cfg_r;
  gmdm_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_AXIS_THRESHOLD:     cfg_nxt.axis_threshold     = cfg_wdata[6:0];
        CFG_STICK_FIXED_SPEED:  cfg_nxt.stick_fixed_speed  = cfg_wdata;
        CFG_BUTTON_FIXED_SPEED: cfg_nxt.button_fixed_speed = cfg_wdata;
        CFG_DEBOUNCE_SECONDS:   cfg_nxt.debounce_seconds   = cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.axis_threshold     <= RST_AXIS_THRESHOLD;
      cfg_r.stick_fixed_speed  <= RST_STICK_FIXED_SPEED;
      cfg_r.button_fixed_speed <= RST_BUTTON_FIXED_SPEED;
      cfg_r.debounce_seconds   <= RST_DEBOUNCE_SECONDS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/gmdm_in_stage.sv
// Input register of the drive mixer: holds one accepted gamepad report.
// Depends on gmdm_pkg.
`timescale 1ns / 1ps

module gmdm_in_stage import gmdm_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  gmdm_report_t in_report,
  input  logic         advance,
  output gmdm_stage_t  stage
);

  logic         valid_r;
  logic         valid_nxt;
  gmdm_report_t report_r;

  // The held report leaves in the same cycle that a new one may enter.
  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      report_r <= in_report;
    end
  end

  assign stage.valid  = valid_r;
  assign stage.report = report_r;

endmodule

>>> rtl/gmdm_mixer.sv
// Drive state and mixing logic: mode buttons, select debounce and the
// manual priority chain. The state register doubles as the result register.
// Depends on gmdm_pkg.
`timescale 1ns / 1ps

module gmdm_mixer import gmdm_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  gmdm_cfg_t    cfg,
  input  gmdm_stage_t  stage,
  output logic         advance,
  input  logic         out_ready,
  output logic         out_valid,
  output gmdm_result_t result
);

  gmdm_result_t res_r;
  gmdm_result_t res_nxt;
  logic         link_r;
  logic         link_nxt;
  logic [31:0]  sel_time_r;
  logic [31:0]  sel_time_nxt;
  logic         out_valid_r;

  gmdm_report_t      rep;
  logic signed [8:0] thr;
  logic signed [8:0] nthr;
  logic signed [8:0] lx;
  logic signed [8:0] ly;
  logic signed [8:0] rx;
  logic signed [8:0] ry;
  logic [31:0]       elapsed;
  logic              fixed;
  logic [7:0]        sf;
  logic [7:0]        bs;

  function automatic logic [7:0] mag8(logic signed [7:0] v);
    return v[7] ? (~v + 8'd1) : v;
  endfunction

  function automatic gmdm_result_t drive4(gmdm_result_t base, dir_t fr, dir_t fl,
                                          dir_t rr, dir_t rl, logic [7:0] s);
    gmdm_result_t r;
    r          = base;
    r.dir_fr   = fr;
    r.dir_fl   = fl;
    r.dir_rr   = rr;
    r.dir_rl   = rl;
    r.speed_fr = s;
    r.speed_fl = s;
    r.speed_rr = s;
    r.speed_rl = s;
    return r;
  endfunction

  assign advance = stage.valid && (!out_valid_r || out_ready);
  assign rep     = stage.report;

  assign thr     = $signed({2'b00, cfg.axis_threshold});
  assign nthr    = -thr;
  assign lx      = $signed({rep.left_x[7], rep.left_x});
  assign ly      = $signed({rep.left_y[7], rep.left_y});
  assign rx      = $signed({rep.right_x[7], rep.right_x});
  assign ry      = $signed({rep.right_y[7], rep.right_y});
  assign elapsed = rep.now_seconds - sel_time_r;
  assign sf      = cfg.stick_fixed_speed;
  assign bs      = cfg.button_fixed_speed;

  always_comb begin
    res_nxt      = res_r;
    link_nxt     = link_r;
    sel_time_nxt = sel_time_r;
    fixed        = 1'b0;

    if (rep.button == BTN_START) begin
      link_nxt = 1'b1;
    end else if (link_r) begin
      // A mode button stops the wheels only when the mode really changes.
      priority if (rep.button == BTN_SQUARE && res_r.drive_mode != MODE_FIXED) begin
        res_nxt = drive4(res_r, DIR_STOP, DIR_STOP, DIR_STOP, DIR_STOP, 8'd0);
        res_nxt.drive_mode = MODE_FIXED;
      end else if (rep.button == BTN_CROSS && res_r.drive_mode != MODE_VAR) begin
        res_nxt = drive4(res_r, DIR_STOP, DIR_STOP, DIR_STOP, DIR_STOP, 8'd0);
        res_nxt.drive_mode = MODE_VAR;
      end else if (rep.button == BTN_CIRCLE && res_r.drive_mode != MODE_EXT) begin
        res_nxt = drive4(res_r, DIR_STOP, DIR_STOP, DIR_STOP, DIR_STOP, 8'd0);
        res_nxt.drive_mode = MODE_EXT;
      end else if (rep.button == BTN_SELECT) begin
        priority if (sel_time_r == 32'd0) begin
          sel_time_nxt           = rep.now_seconds;
          res_nxt.motors_enabled = !res_r.motors_enabled;
        end else if (elapsed < {24'd0, cfg.debounce_seconds}) begin
          sel_time_nxt = sel_time_r;
        end else begin
          sel_time_nxt = 32'd0;
        end
      end else begin
        res_nxt = res_r;
      end

      fixed = (res_nxt.drive_mode == MODE_FIXED);

      if (res_nxt.drive_mode != MODE_EXT) begin
        priority if (ly > thr) begin
          res_nxt = drive4(res_nxt, DIR_FWD, DIR_FWD, DIR_FWD, DIR_FWD,
                           fixed ? sf : mag8(rep.left_y));
        end else if (ry > thr) begin
          res_nxt = drive4(res_nxt, DIR_FWD, DIR_FWD, DIR_FWD, DIR_FWD,
                           fixed ? sf : mag8(rep.right_y));
        end else if (ly < nthr) begin
          res_nxt = drive4(res_nxt, DIR_BACK, DIR_BACK, DIR_BACK, DIR_BACK,
                           fixed ? sf : mag8(rep.left_y));
        end else if (ry < nthr) begin
          res_nxt = drive4(res_nxt, DIR_BACK, DIR_BACK, DIR_BACK, DIR_BACK,
                           fixed ? sf : mag8(rep.right_y));
        end else if (lx < nthr) begin
          res_nxt = drive4(res_nxt, DIR_FWD, DIR_BACK, DIR_FWD, DIR_BACK,
                           fixed ? sf : mag8(rep.left_x));
        end else if (lx > thr) begin
          res_nxt = drive4(res_nxt, DIR_BACK, DIR_FWD, DIR_BACK, DIR_FWD,
                           fixed ? sf : mag8(rep.left_x));
        end else if (rx < nthr) begin
          res_nxt = drive4(res_nxt, DIR_FWD, DIR_BACK, DIR_BACK, DIR_FWD,
                           fixed ? sf : mag8(rep.right_x));
        end else if (rx > thr) begin
          res_nxt = drive4(res_nxt, DIR_BACK, DIR_FWD, DIR_FWD, DIR_BACK,
                           fixed ? sf : mag8(rep.right_x));
        end else if (rep.button == BTN_L1 || rep.button == BTN_L2) begin
          // Diagonal moves turn two wheels; the idle pair keeps its direction.
          res_nxt.dir_fr   = (rep.button == BTN_L1) ? DIR_FWD : DIR_BACK;
          res_nxt.dir_rl   = (rep.button == BTN_L1) ? DIR_FWD : DIR_BACK;
          res_nxt.speed_fr = bs;
          res_nxt.speed_fl = 8'd0;
          res_nxt.speed_rr = 8'd0;
          res_nxt.speed_rl = bs;
        end else if (rep.button == BTN_R1 || rep.button == BTN_R2) begin
          res_nxt.dir_fl   = (rep.button == BTN_R1) ? DIR_FWD : DIR_BACK;
          res_nxt.dir_rr   = (rep.button == BTN_R1) ? DIR_FWD : DIR_BACK;
          res_nxt.speed_fr = 8'd0;
          res_nxt.speed_fl = bs;
          res_nxt.speed_rr = bs;
          res_nxt.speed_rl = 8'd0;
        end else begin
          res_nxt = drive4(res_nxt, DIR_STOP, DIR_STOP, DIR_STOP, DIR_STOP, 8'd0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r       <= '{drive_mode: INITIAL_MODE, motors_enabled: INITIAL_MOTORS_ON,
                       speed_rl: 8'd0, speed_rr: 8'd0, speed_fl: 8'd0, speed_fr: 8'd0,
                       dir_rl: DIR_STOP, dir_rr: DIR_STOP, dir_fl: DIR_STOP,
                       dir_fr: DIR_STOP};
      link_r      <= 1'b0;
      sel_time_r  <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        res_r      <= res_nxt;
        link_r     <= link_nxt;
        sel_time_r <= sel_time_nxt;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign result    = res_r;

  // A stopped wheel never carries a speed.
  a_stop_no_speed: assert property (@(posedge clk) disable iff (!rst_n)
    (res_r.dir_fr != DIR_STOP || res_r.speed_fr == 8'd0) &&
    (res_r.dir_fl != DIR_STOP || res_r.speed_fl == 8'd0) &&
    (res_r.dir_rr != DIR_STOP || res_r.speed_rr == 8'd0) &&
    (res_r.dir_rl != DIR_STOP || res_r.speed_rl == 8'd0))
    else $error("stopped wheel with nonzero speed");

  // Without a transfer the drive state must not move.
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(res_r) && $stable(sel_time_r) && $stable(link_r))
    else $error("drive state changed without a transfer");

  // Once enabled, the link stays enabled until reset.
  a_link_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    link_r |=> link_r)
    else $error("link enable dropped");

  // Before the link is enabled, no report may touch the drive state.
  a_no_link_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !link_r |=> $stable(res_r) && $stable(sel_time_r))
    else $error("drive state changed while link disabled");

  // A result held back by the sink stays valid.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(res_r))
    else $error("stalled result lost");

endmodule

>>> rtl/gamepad_mecanum_drive_mixer_top.sv
// Top level of the gamepad mecanum drive mixer: input register, config
// registers and the mixer. Depends on gmdm_pkg, gmdm_cfg_regs,
// gmdm_in_stage and gmdm_mixer.
//
//   Channel  Direction  Width  Contents
//   in_      slave      72     gamepad report
//   out_     master     48     drive state after the report
//   cfg_     write      8      register index 0..3, no read-back
//
// One report per clock cycle is sustained while out_tready is high; a report
// enters the input register at its transfer edge and then the output register.
// The drive state register is the output register, so a stalled output
// holds one report in the input register and the input side then stalls.
// rst_n is synchronous and clears both channels and the drive state.
`timescale 1ns / 1ps

module gamepad_mecanum_drive_mixer_top import gmdm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] button, [11:4] left_x, [19:12] left_y, [27:20] right_x,
  // [35:28] right_y, [67:36] now_seconds, [71:68] zero
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] dir_front_right, [3:2] dir_front_left, [5:4] dir_rear_right,
  // [7:6] dir_rear_left, [15:8] speed_front_right, [23:16] speed_front_left,
  // [31:24] speed_rear_right, [39:32] speed_rear_left, [40] motors_enabled,
  // [42:41] drive_mode, [47:43] zero
  output logic [47:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  gmdm_cfg_t    cfg;
  gmdm_stage_t  stage;
  gmdm_result_t result;
  logic         advance;

  gmdm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  gmdm_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_report (gmdm_report_t'(in_tdata[REPORT_W-1:0])),
    .advance   (advance),
    .stage     (stage)
  );

  gmdm_mixer u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .stage     (stage),
    .advance   (advance),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .result    (result)
  );

  assign out_tdata = {{(48 - RESULT_W){1'b0}}, result};

endmodule

>>> tb/gamepad_mecanum_drive_mixer_top_tb.sv
// Self-checking testbench for the gamepad mecanum drive mixer top level.
// Holds a drive state scoreboard class, stream drivers and a register writer.
// Depends on gmdm_pkg and gamepad_mecanum_drive_mixer_top.
`timescale 1ns / 1ps

module gamepad_mecanum_drive_mixer_top_tb;
  import gmdm_pkg::*;

  localparam int RANDOM_REPORTS    = 1400;
  localparam int PHASES            = 6;
  localparam int LONG_STALL_CYCLES = 300;
  localparam int SETTLE_CYCLES     = 4;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [7:0]  cfg_wdata;

  gamepad_mecanum_drive_mixer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Tracks the drive state the mixer should hold and the results still owed.
  class drive_state_scoreboard;
    logic [6:0]   thr_cfg;
    logic [7:0]   stick_spd_cfg;
    logic [7:0]   btn_spd_cfg;
    logic [7:0]   debounce_cfg;
    bit           link_on;
    logic [1:0]   mode;
    bit           motors_on;
    logic [31:0]  select_time;
    dir_t         dir [4];
    logic [7:0]   spd [4];
    gmdm_result_t expected_states [$];
    int           mismatches;

    function new();
      thr_cfg       = RST_AXIS_THRESHOLD;
      stick_spd_cfg = RST_STICK_FIXED_SPEED;
      btn_spd_cfg   = RST_BUTTON_FIXED_SPEED;
      debounce_cfg  = RST_DEBOUNCE_SECONDS;
      link_on       = 1'b0;
      mode          = INITIAL_MODE;
      motors_on     = INITIAL_MOTORS_ON;
      select_time   = '0;
      mismatches    = 0;
      stop_wheels();
    endfunction

    function void set_register(logic [1:0] idx, logic [7:0] val);
      case (idx)
        CFG_AXIS_THRESHOLD:     thr_cfg = val[6:0];
        CFG_STICK_FIXED_SPEED:  stick_spd_cfg = val;
        CFG_BUTTON_FIXED_SPEED: btn_spd_cfg = val;
        CFG_DEBOUNCE_SECONDS:   debounce_cfg = val;
        default: ;
      endcase
    endfunction

    function void stop_wheels();
      for (int k = 0; k < 4; k++) begin
        dir[k] = DIR_STOP;
        spd[k] = '0;
      end
    endfunction

    function void change_mode(logic [1:0] m);
      if (mode != m) begin
        stop_wheels();
        mode = m;
      end
    endfunction

    // Wheel order is front right, front left, rear right, rear left.
    function void drive_all(dir_t fr, dir_t fl, dir_t rr, dir_t rl, int magnitude);
      logic [31:0] m;
      logic [7:0]  s;
      m = magnitude;
      s = (mode == MODE_FIXED) ? stick_spd_cfg : m[7:0];
      dir[0] = fr;
      dir[1] = fl;
      dir[2] = rr;
      dir[3] = rl;
      for (int k = 0; k < 4; k++) spd[k] = s;
    endfunction

    function void note_report(gmdm_report_t r);
      int           lx, ly, rx, ry, thr;
      logic [31:0]  elapsed;
      gmdm_result_t res;
      lx  = $signed(r.left_x);
      ly  = $signed(r.left_y);
      rx  = $signed(r.right_x);
      ry  = $signed(r.right_y);
      thr = thr_cfg;
      if (r.button == BTN_START) begin
        link_on = 1'b1;
      end else if (link_on) begin
        case (r.button)
          BTN_SQUARE: change_mode(MODE_FIXED);
          BTN_CROSS:  change_mode(MODE_VAR);
          BTN_CIRCLE: change_mode(MODE_EXT);
          BTN_SELECT: begin
            elapsed = r.now_seconds - select_time;
            if (select_time == 0) begin
              select_time = r.now_seconds;
              motors_on   = !motors_on;
            end else if (elapsed >= {24'd0, debounce_cfg}) begin
              select_time = '0;
            end
          end
          default: ;
        endcase
        if (mode != MODE_EXT) begin
          if (ly > thr)       drive_all(DIR_FWD, DIR_FWD, DIR_FWD, DIR_FWD, ly);
          else if (ry > thr)  drive_all(DIR_FWD, DIR_FWD, DIR_FWD, DIR_FWD, ry);
          else if (ly < -thr) drive_all(DIR_BACK, DIR_BACK, DIR_BACK, DIR_BACK, -ly);
          else if (ry < -thr) drive_all(DIR_BACK, DIR_BACK, DIR_BACK, DIR_BACK, -ry);
          else if (lx < -thr) drive_all(DIR_FWD, DIR_BACK, DIR_FWD, DIR_BACK, -lx);
          else if (lx > thr)  drive_all(DIR_BACK, DIR_FWD, DIR_BACK, DIR_FWD, lx);
          else if (rx < -thr) drive_all(DIR_FWD, DIR_BACK, DIR_BACK, DIR_FWD, -rx);
          else if (rx > thr)  drive_all(DIR_BACK, DIR_FWD, DIR_FWD, DIR_BACK, rx);
          else if (r.button == BTN_L1 || r.button == BTN_L2) begin
            // Diagonal: the two idle wheels keep their direction at zero speed.
            dir[0] = (r.button == BTN_L1) ? DIR_FWD : DIR_BACK;
            dir[3] = dir[0];
            spd[0] = btn_spd_cfg;
            spd[1] = '0;
            spd[2] = '0;
            spd[3] = btn_spd_cfg;
          end else if (r.button == BTN_R1 || r.button == BTN_R2) begin
            dir[1] = (r.button == BTN_R1) ? DIR_FWD : DIR_BACK;
            dir[2] = dir[1];
            spd[0] = '0;
            spd[1] = btn_spd_cfg;
            spd[2] = btn_spd_cfg;
            spd[3] = '0;
          end else begin
            stop_wheels();
          end
        end
      end
      res.dir_fr         = dir[0];
      res.dir_fl         = dir[1];
      res.dir_rr         = dir[2];
      res.dir_rl         = dir[3];
      res.speed_fr       = spd[0];
      res.speed_fl       = spd[1];
      res.speed_rr       = spd[2];
      res.speed_rl       = spd[3];
      res.motors_enabled = motors_on;
      res.drive_mode     = mode;
      expected_states.push_back(res);
    endfunction

    function void field_check(string name, int want, int got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, name, want, got);
      end
    endfunction

    function void check_result(logic [47:0] data);
      gmdm_result_t got, want;
      got = gmdm_result_t'(data[RESULT_W-1:0]);
      if (expected_states.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result 0x%012h", $realtime, data);
        return;
      end
      want = expected_states.pop_front();
      field_check("dir_front_right", int'(want.dir_fr), int'(got.dir_fr));
      field_check("dir_front_left", int'(want.dir_fl), int'(got.dir_fl));
      field_check("dir_rear_right", int'(want.dir_rr), int'(got.dir_rr));
      field_check("dir_rear_left", int'(want.dir_rl), int'(got.dir_rl));
      field_check("speed_front_right", want.speed_fr, got.speed_fr);
      field_check("speed_front_left", want.speed_fl, got.speed_fl);
      field_check("speed_rear_right", want.speed_rr, got.speed_rr);
      field_check("speed_rear_left", want.speed_rl, got.speed_rl);
      field_check("motors_enabled", want.motors_enabled, got.motors_enabled);
      field_check("drive_mode", want.drive_mode, got.drive_mode);
    endfunction
  endclass

  drive_state_scoreboard board;
  int                    send_idle_pct = 14;
  int                    recv_idle_pct = 70;
  bit                    long_stall_req = 1'b0;
  logic [31:0]           clock_secs;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Both channels are observed on the same edge at which the transfer happens.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      board.note_report(gmdm_report_t'(in_tdata[REPORT_W-1:0]));
    if (rst_n && out_tvalid && out_tready)
      board.check_result(out_tdata);
  end

  // Result side: random back-pressure, or one long hold-off when requested.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_STALL_CYCLES) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic gmdm_report_t report_of(logic [3:0] btn, logic [7:0] lx, logic [7:0] ly,
                                             logic [7:0] rx, logic [7:0] ry,
                                             logic [31:0] secs);
    gmdm_report_t r;
    r.button      = btn;
    r.left_x      = lx;
    r.left_y      = ly;
    r.right_x     = rx;
    r.right_y     = ry;
    r.now_seconds = secs;
    return r;
  endfunction

  // Mostly below the threshold so that later links of the priority chain are reached.
  function automatic logic [7:0] random_axis();
    int t, pick;
    t    = board.thr_cfg;
    pick = $urandom_range(99, 0);
    if (pick < 30) return 8'($urandom_range(255, 0));
    if (pick < 40) begin
      case ($urandom_range(3, 0))
        0: return 8'(t);
        1: return 8'(t + 1);
        2: return 8'(-t);
        default: return 8'(-t - 1);
      endcase
    end
    return 8'(int'($urandom_range(2 * t, 0)) - t);
  endfunction

  function automatic gmdm_report_t random_report();
    int         pick;
    logic [3:0] btn;
    pick = $urandom_range(99, 0);
    if (pick < 35)      btn = BTN_NONE;
    else if (pick < 38) btn = BTN_START;
    else if (pick < 50) btn = BTN_SELECT;
    else if (pick < 54) btn = BTN_SQUARE;
    else if (pick < 58) btn = BTN_CROSS;
    else if (pick < 61) btn = BTN_CIRCLE;
    else if (pick < 85) btn = BTN_L1 + 4'($urandom_range(3, 0));
    else if (pick < 92) btn = 4'($urandom_range(15, 10));
    else                btn = 4'($urandom_range(15, 0));
    if ($urandom_range(99, 0) < 3) clock_secs = $urandom();
    else                           clock_secs = clock_secs + $urandom_range(3, 0);
    return report_of(btn, random_axis(), random_axis(), random_axis(), random_axis(),
                     clock_secs);
  endfunction

  task automatic send_report(input gmdm_report_t r);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, r};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_for_drain();
    while (board.expected_states.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.set_register(idx, val);
  endtask

  task automatic write_settings(input logic [6:0] thr, input logic [7:0] stick_spd,
                                input logic [7:0] btn_spd, input logic [7:0] debounce);
    write_reg(CFG_AXIS_THRESHOLD, {1'b0, thr});
    write_reg(CFG_STICK_FIXED_SPEED, stick_spd);
    write_reg(CFG_BUTTON_FIXED_SPEED, btn_spd);
    write_reg(CFG_DEBOUNCE_SECONDS, debounce);
    cfg_we <= 1'b0;
  endtask

  initial begin
    board      = new();
    clock_secs = 32'd10;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part with the reset settings. Before START nothing but START counts.
    send_report(report_of(BTN_SELECT, 8'd127, 8'd0, 8'd0, 8'd0, 32'd3));
    send_report(report_of(BTN_CIRCLE, 8'd0, 8'd127, 8'd0, 8'd0, 32'd3));
    send_report(report_of(BTN_START, 8'd0, 8'd127, 8'd0, 8'd0, 32'd3));
    send_report(report_of(BTN_NONE, 8'd0, 8'd127, 8'd0, 8'd0, 32'd4));
    send_report(report_of(BTN_NONE, 8'd0, -8'sd128, 8'd0, 8'd0, 32'd4));
    send_report(report_of(BTN_NONE, 8'd0, 8'd0, 8'd0, 8'd127, 32'd4));
    send_report(report_of(BTN_NONE, 8'd0, 8'd0, 8'd0, -8'sd128, 32'd4));
    send_report(report_of(BTN_NONE, -8'sd128, 8'd0, 8'd0, 8'd0, 32'd4));
    send_report(report_of(BTN_NONE, 8'd127, 8'd0, 8'd0, 8'd0, 32'd4));
    send_report(report_of(BTN_NONE, 8'd0, 8'd0, -8'sd128, 8'd0, 32'd4));
    send_report(report_of(BTN_NONE, 8'd0, 8'd0, 8'd127, 8'd0, 32'd4));
    send_report(report_of(BTN_L1, 8'd0, 8'd0, 8'd0, 8'd0, 32'd5));
    send_report(report_of(BTN_R2, 8'd0, 8'd0, 8'd0, 8'd0, 32'd5));
    send_report(report_of(BTN_L2, 8'd0, 8'd0, 8'd0, 8'd0, 32'd5));
    send_report(report_of(BTN_R1, 8'd0, 8'd0, 8'd0, 8'd0, 32'd5));
    send_report(report_of(4'd15, 8'd0, 8'd0, 8'd0, 8'd0, 32'd5));
    send_report(report_of(BTN_SQUARE, 8'd0, 8'd21, 8'd0, 8'd0, 32'd6));
    send_report(report_of(BTN_SQUARE, 8'd0, 8'd20, 8'd0, -8'sd20, 32'd6));
    send_report(report_of(BTN_CIRCLE, 8'd0, 8'd127, 8'd0, 8'd0, 32'd6));
    send_report(report_of(BTN_NONE, 8'd127, 8'd127, 8'd0, 8'd0, 32'd6));
    // A press at time zero keeps no stored time, so the next press toggles again.
    send_report(report_of(BTN_SELECT, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0));
    send_report(report_of(BTN_SELECT, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0));
    send_report(report_of(BTN_SELECT, 8'd0, 8'd0, 8'd0, 8'd0, 32'hFFFF_FFFF));
    send_report(report_of(BTN_SELECT, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0));
    send_report(report_of(BTN_CROSS, 8'd0, 8'd0, 8'd0, 8'd0, 32'd7));
    send_report(report_of(BTN_START, 8'd0, 8'd0, -8'sd128, 8'd0, 32'd7));
    in_tvalid <= 1'b0;

    for (int phase = 0; phase < PHASES; phase++) begin
      send_idle_pct = (phase < 2) ? 14 : (phase < 4) ? 70 : 0;
      recv_idle_pct = (phase < 2) ? 70 : (phase < 4) ? 14 : 0;
      wait_for_drain();
      case (phase)
        0: write_settings(7'd20, 8'd100, 8'd100, 8'd1);
        1: write_settings(7'd0, 8'd0, 8'd255, 8'd0);
        2: write_settings(7'd127, 8'd255, 8'd0, 8'd255);
        4: write_settings(7'd5, 8'd1, 8'd77, 8'd3);
        default: write_settings(7'($urandom_range(127, 0)), 8'($urandom_range(255, 0)),
                                8'($urandom_range(255, 0)), 8'($urandom_range(8, 0)));
      endcase
      for (int i = 0; i < RANDOM_REPORTS / PHASES; i++) begin
        // The long hold-off fills the block while reports keep coming.
        if (phase == 4 && i == 60) long_stall_req = 1'b1;
        if (phase == 4 && i == 150) begin
          in_tvalid <= 1'b0;
          wait_for_drain();
        end
        send_report(random_report());
      end
      in_tvalid <= 1'b0;
    end

    wait_for_drain();
    repeat (10) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/gmdm_pkg.sv
rtl/gmdm_cfg_regs.sv
rtl/gmdm_in_stage.sv
rtl/gmdm_mixer.sv
rtl/gamepad_mecanum_drive_mixer_top.sv
tb/gamepad_mecanum_drive_mixer_top_tb.sv
